[sv/ppc_pkg.sv]
// ----------------------------------------------------------------------------
// Polar pose controller package
// Shared types, constants, register indexes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none
package ppc_pkg;

	localparam int unsigned CordicStepsDefault = 16;
	localparam int unsigned AtanEntries        = 24;

	// Configuration register indexes.
	localparam logic [2:0] RegGoalX          = 3'd0;
	localparam logic [2:0] RegGoalY          = 3'd1;
	localparam logic [2:0] RegGoalHeading    = 3'd2;
	localparam logic [2:0] RegGainDistance   = 3'd3;
	localparam logic [2:0] RegGainBearing    = 3'd4;
	localparam logic [2:0] RegGainFinalAngle = 3'd5;
	localparam logic [2:0] RegArriveDistance = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_ITER,
		ST_ANGLE,
		ST_MUL,
		ST_OUT
	} ppc_state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;     // capture pose, form differences
		logic prep;     // square sum, arrival test, CORDIC pre-rotation
		logic iter;     // one CORDIC and one square-root step
		logic angle;    // form alpha and beta
		logic mul;      // gain products
		logic finish;   // rounding, saturation, result register
	} ppc_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic arrive;   // this item arrives (latch or threshold)
		logic iter_done;
	} ppc_sts_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		case (i)
			5'd0:  r = 32'h20000000;
			5'd1:  r = 32'h12E4051E;
			5'd2:  r = 32'h09FB385B;
			5'd3:  r = 32'h051111D4;
			5'd4:  r = 32'h028B0D43;
			5'd5:  r = 32'h0145D7E1;
			5'd6:  r = 32'h00A2F61E;
			5'd7:  r = 32'h00517C55;
			5'd8:  r = 32'h0028BE53;
			5'd9:  r = 32'h00145F2F;
			5'd10: r = 32'h000A2F98;
			5'd11: r = 32'h000517CC;
			5'd12: r = 32'h00028BE6;
			5'd13: r = 32'h000145F3;
			5'd14: r = 32'h0000A2FA;
			5'd15: r = 32'h0000517D;
			5'd16: r = 32'h000028BE;
			5'd17: r = 32'h0000145F;
			5'd18: r = 32'h00000A30;
			5'd19: r = 32'h00000518;
			5'd20: r = 32'h0000028C;
			5'd21: r = 32'h00000146;
			5'd22: r = 32'h000000A3;
			5'd23: r = 32'h00000051;
			default: r = 32'h0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/ppc_if.sv]
// ----------------------------------------------------------------------------
// Polar pose controller channel interfaces
// Valid/ready channels for pose words, result words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface ppc_pose_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pose_x;
	logic signed [15:0] pose_y;
	logic signed [15:0] pose_heading;
	modport source (output valid, pose_x, pose_y, pose_heading, input ready);
	modport sink (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

interface ppc_cmd_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] velocity;
	logic signed [19:0] steering;
	logic               arrived;
	modport source (output valid, velocity, steering, arrived, input ready);
	modport sink (input valid, velocity, steering, arrived, output ready);
endinterface

interface ppc_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[sv/polar_pose_controller_top.sv]
// ----------------------------------------------------------------------------
// Polar pose controller
// Go-to-pose control law for a unicycle robot on valid/ready channels.
// ----------------------------------------------------------------------------
// Each pose steps through load, preparation, the shared CORDIC and square-root
// iteration loop, angles, gain products and output; an arriving pose skips the
// loop, angles and products. One pose at a time: the next pose is taken in the
// cycle after a result word is loaded, which waits while the result side stalls.
// Asynchronous reset clears control, the arrival latch and the output valid, and
// loads register defaults.
`default_nettype none
module polar_pose_controller_top #(
	parameter int unsigned CORDIC_STEPS = ppc_pkg::CordicStepsDefault
) (
	input wire clk,
	input wire arst_n,
	ppc_pose_if.sink pose,
	ppc_cmd_if.source cmd_out,
	ppc_cfg_if.sink cfg
);
	import ppc_pkg::*;

	logic signed [15:0] goal_x_q, goal_y_q, goal_heading_q;
	logic signed [11:0] gain_distance_q, gain_bearing_q, gain_final_angle_q;
	logic        [15:0] arrive_distance_q;
	logic               out_valid_q;
	logic               out_free;
	ppc_cmd_t           cmd;
	ppc_sts_t           sts;

	assign cfg.ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q           <= '0;
			goal_y_q           <= '0;
			goal_heading_q     <= '0;
			gain_distance_q    <= 12'sd256;
			gain_bearing_q     <= 12'sd1280;
			gain_final_angle_q <= -12'sd512;
			arrive_distance_q  <= 16'd20;
		end else if (cfg.valid) begin
			case (cfg.index)
				RegGoalX:          goal_x_q           <= cfg.data;
				RegGoalY:          goal_y_q           <= cfg.data;
				RegGoalHeading:    goal_heading_q     <= cfg.data;
				RegGainDistance:   gain_distance_q    <= cfg.data[11:0];
				RegGainBearing:    gain_bearing_q     <= cfg.data[11:0];
				RegGainFinalAngle: gain_final_angle_q <= cfg.data[11:0];
				RegArriveDistance: arrive_distance_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Output word valid flag.
	assign out_free = !out_valid_q || cmd_out.ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (cmd_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end
	assign cmd_out.valid = out_valid_q;

	ppc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pose.valid),
		.in_ready (pose.ready),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd)
	);

	ppc_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.pose_x           (pose.pose_x),
		.pose_y           (pose.pose_y),
		.pose_heading     (pose.pose_heading),
		.goal_x           (goal_x_q),
		.goal_y           (goal_y_q),
		.gain_distance    (gain_distance_q),
		.gain_bearing     (gain_bearing_q),
		.gain_final_angle (gain_final_angle_q),
		.arrive_distance  (arrive_distance_q),
		.velocity         (cmd_out.velocity),
		.steering         (cmd_out.steering),
		.arrived          (cmd_out.arrived)
	);

	// An arrived word carries zero commands.
	a_zero_when_arrived: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_out.valid && cmd_out.arrived |-> cmd_out.velocity == 0 && cmd_out.steering == 0)
		else $error("arrived word with nonzero command");

	// A pose is only taken while no result word is being produced.
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !pose.ready)
		else $error("pose taken while busy");

	// A result word is only loaded when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !cmd_out.valid || cmd_out.ready)
		else $error("result word overwritten");
endmodule
`default_nettype wire

[sv/ppc_ctrl.sv]
// ----------------------------------------------------------------------------
// Polar pose controller sequencer
// Steps one pose word through preparation, CORDIC iterations and output.
// ----------------------------------------------------------------------------
`default_nettype none
module ppc_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  wire                 out_free,
	input  ppc_pkg::ppc_sts_t   sts,
	output ppc_pkg::ppc_cmd_t   cmd
);
	import ppc_pkg::*;

	ppc_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_ITER;
			end
			ST_ITER: begin
				if (sts.arrive) begin
					state_d = ST_OUT;
				end else begin
					cmd.iter = 1'b1;
					if (sts.iter_done) begin
						state_d = ST_ANGLE;
					end
				end
			end
			ST_ANGLE: begin
				cmd.angle = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

[sv/ppc_dp.sv]
// ----------------------------------------------------------------------------
// Polar pose controller datapath
// Differences, square sum, arrival test, CORDIC arctangent, bit-pair square
// root, gain products and saturation.
// ----------------------------------------------------------------------------
`default_nettype none
module ppc_dp #(
	parameter int unsigned CORDIC_STEPS = ppc_pkg::CordicStepsDefault
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ppc_pkg::ppc_cmd_t   cmd,
	output ppc_pkg::ppc_sts_t   sts,
	input  wire signed [15:0]   pose_x,
	input  wire signed [15:0]   pose_y,
	input  wire signed [15:0]   pose_heading,
	input  wire signed [15:0]   goal_x,
	input  wire signed [15:0]   goal_y,
	input  wire signed [11:0]   gain_distance,
	input  wire signed [11:0]   gain_bearing,
	input  wire signed [11:0]   gain_final_angle,
	input  wire        [15:0]   arrive_distance,
	output logic signed [15:0]  velocity,
	output logic signed [19:0]  steering,
	output logic                arrived
);
	import ppc_pkg::*;

	// Steps actually run: at most the table length; square root needs 17.
	localparam int unsigned NSteps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
	localparam int unsigned NIter  = (NSteps > 17) ? NSteps : 17;
	localparam logic [4:0]  LastIt = 5'(NIter - 1);

	logic signed [16:0] dx_q, dy_q;
	logic        [15:0] th_q;
	logic        [34:0] sq_q;      // square sum, then square-root remainder
	logic        [16:0] root_q;
	logic signed [33:0] cx_q, cy_q;
	logic        [31:0] z_q;
	logic        [4:0]  it_q;
	logic               latch_q;
	logic               arrive_q;
	logic signed [15:0] alpha_q, beta_q;
	logic signed [28:0] pv_q;
	logic signed [28:0] pa_q, pb_q;

	logic [33:0] sq_d;
	logic [35:0] thr2;
	logic signed [33:0] xs, ys;
	logic [31:0] a32;
	logic [15:0] al16;
	logic [35:0] rem_w, trial;
	logic [16:0] root_w;
	logic signed [29:0] steer_sum;
	logic signed [21:0] vr;
	logic signed [22:0] sr;

	assign sq_d = 34'(dx_q * dx_q) + 34'(dy_q * dy_q);
	assign thr2 = 36'(arrive_distance * arrive_distance);
	assign xs   = cx_q >>> it_q;
	assign ys   = cy_q >>> it_q;
	assign a32  = z_q - {th_q, 16'h0};
	assign al16 = 16'((a32 + 32'h8000) >> 16);

	// Restoring square root, one result bit per step from the top.
	always_comb begin
		trial  = 36'({root_q, 2'b01}) << (2 * (16 - 32'(it_q)));
		rem_w  = 36'(sq_q);
		root_w = root_q << 1;
		if (it_q <= 5'd16) begin
			trial = 36'({root_q, 2'b01});
			rem_w = 36'(sq_q);
			if ((36'(sq_q) >> (2 * (16 - 32'(it_q)))) >= trial) begin
				rem_w  = 36'(sq_q) - (trial << (2 * (16 - 32'(it_q))));
				root_w = {root_q[15:0], 1'b1};
			end else begin
				root_w = {root_q[15:0], 1'b0};
			end
		end else begin
			root_w = root_q;
		end
	end

	assign steer_sum = 30'(pa_q) + 30'(pb_q) + 30'sd128;
	assign vr        = 22'(pv_q + 29'sd128 >>> 8);
	assign sr        = 23'(steer_sum >>> 8);

	assign sts.arrive    = arrive_q;
	assign sts.iter_done = (it_q == LastIt);

	// Arrival latch.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q <= 1'b0;
		end else if (cmd.prep && arrive_q) begin
			latch_q <= 1'b1;
		end else if (cmd.prep && (latch_q || 36'(sq_d) <= thr2)) begin
			latch_q <= 1'b1;
		end
	end

	// Working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dx_q <= 17'(goal_x) - 17'(pose_x);
			dy_q <= 17'(goal_y) - 17'(pose_y);
			th_q <= pose_heading;
		end
		if (cmd.prep) begin
			sq_q     <= 35'(sq_d);
			root_q   <= '0;
			it_q     <= '0;
			arrive_q <= latch_q || (36'(sq_d) <= thr2);
			if (dx_q < 0) begin
				cx_q <= -(34'(dx_q) <<< 14);
				cy_q <= -(34'(dy_q) <<< 14);
				z_q  <= 32'h80000000;
			end else begin
				cx_q <= 34'(dx_q) <<< 14;
				cy_q <= 34'(dy_q) <<< 14;
				z_q  <= '0;
			end
		end
		if (cmd.iter) begin
			it_q   <= it_q + 5'd1;
			sq_q   <= 35'(rem_w);
			root_q <= root_w;
			if (32'(it_q) < NSteps) begin
				if (cy_q >= 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					z_q  <= z_q + atan_lut(it_q);
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					z_q  <= z_q - atan_lut(it_q);
				end
			end
		end
		if (cmd.angle) begin
			alpha_q <= al16;
			beta_q  <= 16'(16'h0 - th_q - al16);
		end
		if (cmd.mul) begin
			pv_q <= 29'(gain_distance * $signed({1'b0, root_q}));
			pa_q <= 29'(gain_bearing * alpha_q);
			pb_q <= 29'(gain_final_angle * beta_q);
		end
	end

	// Result register with saturation.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			arrived <= arrive_q;
			if (arrive_q) begin
				velocity <= '0;
				steering <= '0;
			end else begin
				velocity <= (vr > 22'sd32767) ? 16'sd32767 :
				            (vr < -22'sd32768) ? -16'sd32768 : 16'(vr);
				steering <= (sr > 23'sd524287) ? 20'sd524287 :
				            (sr < -23'sd524288) ? -20'sd524288 : 20'(sr);
			end
		end
	end
endmodule
`default_nettype wire

[bench/ppc_checker.sv]
// ----------------------------------------------------------------------------
// Polar pose controller checker
// Watches the pose, result and register channels, predicts each result word
// from its own copy of the registers and arrival latch, and compares.
// ----------------------------------------------------------------------------
`default_nettype none
module ppc_checker (
	input wire clk,
	input wire arst_n,
	ppc_pose_if pose,
	ppc_cmd_if cmd_out,
	ppc_cfg_if cfg,
	output int fail_count,
	output int pending
);
	import ppc_pkg::*;

	typedef struct {
		logic signed [15:0] velocity;
		logic signed [19:0] steering;
		logic               arrived;
	} cmd_word_t;

	cmd_word_t expected_cmds[$];

	logic signed [15:0] goal_x, goal_y, goal_heading;
	logic signed [11:0] k_rho, k_alpha, k_beta;
	logic [15:0]        arrive_dist;
	logic               arrived_seen;

	assign pending = expected_cmds.size();

	// Integer square root, floor.
	function automatic longint unsigned root_floor(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Bearing of (dx, dy) as a 32-bit binary angle by vectoring rotation.
	function automatic logic [31:0] bearing_angle(input longint dx, input longint dy);
		longint x, y, xs, ys;
		logic [31:0] z;
		x = dx * 16384;
		y = dy * 16384;
		z = 0;
		if (dx == 0 && dy == 0)
			return 32'd0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h80000000;
		end
		for (int i = 0; i < CordicStepsDefault && i < AtanEntries; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_lut(i[4:0]);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_lut(i[4:0]);
			end
		end
		return z;
	endfunction

	// Predicted result word for one pose; updates the arrival latch.
	function automatic cmd_word_t control_law(input logic signed [15:0] px,
			input logic signed [15:0] py, input logic [15:0] th);
		cmd_word_t r;
		longint dx, dy, vel, steer, alpha, beta;
		longint unsigned sq, rho;
		logic [31:0] a32;
		logic [15:0] b16;
		dx = longint'(goal_x) - longint'(px);
		dy = longint'(goal_y) - longint'(py);
		sq = dx * dx + dy * dy;
		if (arrived_seen || sq <= longint'(arrive_dist) * longint'(arrive_dist)) begin
			arrived_seen = 1'b1;
			r.velocity = 0;
			r.steering = 0;
			r.arrived = 1'b1;
			return r;
		end
		rho = root_floor(sq);
		a32 = bearing_angle(dx, dy) - {th, 16'd0};
		a32 = a32 + 32'h8000;
		alpha = longint'($signed(a32[31:16]));
		b16 = 16'd0 - th - a32[31:16];
		beta = longint'($signed(b16));
		vel = (longint'(k_rho) * longint'(rho) + 128) >>> 8;
		if (vel > 32767) vel = 32767;
		if (vel < -32768) vel = -32768;
		steer = (longint'(k_alpha) * alpha + longint'(k_beta) * beta + 128) >>> 8;
		if (steer > 524287) steer = 524287;
		if (steer < -524288) steer = -524288;
		r.velocity = vel[15:0];
		r.steering = steer[19:0];
		r.arrived = 1'b0;
		return r;
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// Track register writes, poses and result words.
	always @(posedge clk or negedge arst_n) begin
		cmd_word_t want;
		if (!arst_n) begin
			goal_x = 0;
			goal_y = 0;
			goal_heading = 0;
			k_rho = 12'sd256;
			k_alpha = 12'sd1280;
			k_beta = -12'sd512;
			arrive_dist = 16'd20;
			arrived_seen = 1'b0;
			fail_count = 0;
			expected_cmds.delete();
		end else begin
			if (cmd_out.valid && cmd_out.ready) begin
				if (expected_cmds.size() == 0) begin
					report("result word with nothing expected");
				end else begin
					want = expected_cmds.pop_front();
					if (cmd_out.velocity !== want.velocity)
						report($sformatf("velocity %0d, expected %0d",
							cmd_out.velocity, want.velocity));
					if (cmd_out.steering !== want.steering)
						report($sformatf("steering %0d, expected %0d",
							cmd_out.steering, want.steering));
					if (cmd_out.arrived !== want.arrived)
						report($sformatf("arrived %b, expected %b",
							cmd_out.arrived, want.arrived));
				end
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					RegGoalX:          goal_x = cfg.data;
					RegGoalY:          goal_y = cfg.data;
					RegGoalHeading:    goal_heading = cfg.data;
					RegGainDistance:   k_rho = cfg.data[11:0];
					RegGainBearing:    k_alpha = cfg.data[11:0];
					RegGainFinalAngle: k_beta = cfg.data[11:0];
					RegArriveDistance: arrive_dist = cfg.data;
					default: ;
				endcase
			end
			if (pose.valid && pose.ready)
				expected_cmds.push_back(control_law(pose.pose_x, pose.pose_y,
					pose.pose_heading));
		end
	end
endmodule
`default_nettype wire

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Polar pose controller testbench
// Drives directed and random poses under several register settings with
// random gaps and stalls; the checker predicts and compares each word.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	import ppc_pkg::*;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   hold_cycles;
	int   long_hold;
	bit   sink_on;

	ppc_pose_if pose ();
	ppc_cmd_if  cmd_out ();
	ppc_cfg_if  cfg ();

	polar_pose_controller_top uut (
		.clk(clk), .arst_n(arst_n), .pose(pose), .cmd_out(cmd_out), .cfg(cfg)
	);

	ppc_checker checker_i (
		.clk(clk), .arst_n(arst_n), .pose(pose), .cmd_out(cmd_out), .cfg(cfg),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(0, 3);
	endfunction

	// Result side: random stalls, and one long hold-off on request.
	initial begin
		cmd_out.ready = 1'b0;
		hold_cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold > 0) begin
				cmd_out.ready <= 1'b0;
				long_hold <= long_hold - 1;
			end else if (!sink_on) begin
				cmd_out.ready <= 1'b1;
			end else if (hold_cycles > 0) begin
				cmd_out.ready <= 1'b0;
				hold_cycles <= hold_cycles - 1;
			end else begin
				cmd_out.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					hold_cycles <= gap_len();
			end
		end
	end

	// One register write; valid drops after acceptance, so writes never overlap.
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_pose(input logic [15:0] px, input logic [15:0] py,
			input logic [15:0] ph, input bit gaps);
		int g;
		pose.valid <= 1'b1;
		pose.pose_x <= px;
		pose.pose_y <= py;
		pose.pose_heading <= ph;
		do @(posedge clk); while (!pose.ready);
		if (gaps) begin
			g = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
			if (g > 0) begin
				pose.valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	endtask

	// Wait until every result word has come, then for the block latency.
	task automatic drain();
		pose.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_all(input logic [15:0] gx, input logic [15:0] gy,
			input logic [15:0] gh, input logic [11:0] kr, input logic [11:0] ka,
			input logic [11:0] kb, input logic [15:0] ad);
		write_reg(RegGoalX, gx);
		write_reg(RegGoalY, gy);
		write_reg(RegGoalHeading, gh);
		write_reg(RegGainDistance, {4'd0, kr});
		write_reg(RegGainBearing, {4'd0, ka});
		write_reg(RegGainFinalAngle, {4'd0, kb});
		write_reg(RegArriveDistance, ad);
	endtask

	// Random gains and goals with a zero arrival distance.
	task automatic set_random();
		set_all(16'($urandom), 16'($urandom), 16'($urandom), 12'($urandom),
			12'($urandom), 12'($urandom), 16'd0);
	endtask

	// Random-content poses; the near percentage lies within 2000 of the origin, the rest anywhere.
	task automatic random_phase(input int count, input int near);
		logic [15:0] px, py;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < near) begin
				px = 16'($urandom_range(0, 4000) - 2000);
				py = 16'($urandom_range(0, 4000) - 2000);
			end else begin
				px = 16'($urandom);
				py = 16'($urandom);
			end
			send_pose(px, py, 16'($urandom), 1'b1);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		long_hold = 0;
		sink_on = 1'b0;
		pose.valid = 1'b0;
		pose.pose_x = '0;
		pose.pose_y = '0;
		pose.pose_heading = '0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed poses under reset defaults; latch left clear by avoiding zero.
		write_reg(RegArriveDistance, 16'd0);
		send_pose(16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
		send_pose(16'h8000, 16'h8000, 16'h7FFF, 1'b0);
		send_pose(16'h8000, 16'h7FFF, 16'h0000, 1'b0);
		send_pose(16'h7FFF, 16'h8000, 16'hFFFF, 1'b0);
		send_pose(16'h0100, 16'h0000, 16'h4000, 1'b0);
		send_pose(16'hFF00, 16'h0000, 16'hC000, 1'b0);
		send_pose(16'h0000, 16'h0100, 16'h0000, 1'b0);
		send_pose(16'h0000, 16'hFF00, 16'h0000, 1'b0);
		send_pose(16'h0001, 16'h0000, 16'h0001, 1'b0);
		drain();

		// Extreme gains and goals: saturation in both directions.
		set_all(16'h8000, 16'h7FFF, 16'h7FFF, 12'h7FF, 12'h7FF, 12'h7FF, 16'd0);
		send_pose(16'h7FFF, 16'h8000, 16'h8000, 1'b0);
		send_pose(16'h7FFF, 16'h7FFF, 16'h4000, 1'b0);
		send_pose(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
		drain();
		set_all(16'h7FFF, 16'h8000, 16'h8000, 12'h800, 12'h800, 12'h800, 16'd0);
		send_pose(16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
		send_pose(16'h0000, 16'h0000, 16'h0000, 1'b0);
		drain();
		sink_on = 1'b1;
		random_phase(60, 30);
		drain();

		// Fresh latch after the single reset is not possible, so the arrival
		// phases come last; first long random phases without arrival.
		set_random();
		random_phase(20, 50);
		drain();
		sink_on = 1'b0;
		set_all(16'h0000, 16'h0000, 16'h0000, 12'd256, 12'd1280, 12'hE00, 16'd0);
		random_phase(200, 50);
		drain();
		sink_on = 1'b1;
		// The receiver holds off while poses keep coming, so input stalls.
		long_hold = 300;
		random_phase(400, 50);
		drain();
		set_random();
		random_phase(400, 40);
		drain();
		set_random();
		random_phase(400, 40);
		drain();

		// Zero vector arrives even with zero threshold, then the latch holds.
		set_all(16'h7FFF, 16'h8000, 16'h0000, 12'd256, 12'd1280, 12'hE00, 16'd0);
		send_pose(16'h7F00, 16'h8000, 16'h1234, 1'b0);
		send_pose(16'h7FFF, 16'h8000, 16'h1234, 1'b0);
		send_pose(16'h0000, 16'h0000, 16'h0000, 1'b0);
		drain();
		// Large threshold: the latch stays set and holds.
		write_reg(RegArriveDistance, 16'hFFFF);
		random_phase(250, 50);
		drain();

		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
sv/ppc_pkg.sv
sv/ppc_if.sv
sv/ppc_ctrl.sv
sv/ppc_dp.sv
sv/polar_pose_controller_top.sv
bench/ppc_checker.sv
bench/tb_top.sv
